// ===== design/cpdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the cascaded PI duty controller.
package cpdc_pkg;

    localparam int unsigned GAIN_W  = 31;
    localparam int unsigned RECIP_W = 17;
    localparam int unsigned PWM_W   = 16;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_OUTER_KP = 3'd0;
    localparam logic [IDX_W-1:0] REG_OUTER_KI = 3'd1;
    localparam logic [IDX_W-1:0] REG_OUTER_KD = 3'd2;
    localparam logic [IDX_W-1:0] REG_INNER_KP = 3'd3;
    localparam logic [IDX_W-1:0] REG_INNER_KI = 3'd4;
    localparam logic [IDX_W-1:0] REG_INNER_KD = 3'd5;
    localparam logic [IDX_W-1:0] REG_RECIP    = 3'd6;
    localparam logic [IDX_W-1:0] REG_PWM_FS   = 3'd7;

    localparam logic [GAIN_W-1:0]  RST_OUTER_KP = 31'd2621;
    localparam logic [GAIN_W-1:0]  RST_OUTER_KI = 31'd1311;
    localparam logic [GAIN_W-1:0]  RST_OUTER_KD = 31'd0;
    localparam logic [GAIN_W-1:0]  RST_INNER_KP = 31'd65536;
    localparam logic [GAIN_W-1:0]  RST_INNER_KI = 31'd0;
    localparam logic [GAIN_W-1:0]  RST_INNER_KD = 31'd0;
    localparam logic [RECIP_W-1:0] RST_RECIP    = 17'd10923;
    localparam logic [PWM_W-1:0]   RST_PWM_FS   = 16'd2250;

    typedef struct packed {
        logic [GAIN_W-1:0]  outer_kp;
        logic [GAIN_W-1:0]  outer_ki;
        logic [GAIN_W-1:0]  outer_kd;
        logic [GAIN_W-1:0]  inner_kp;
        logic [GAIN_W-1:0]  inner_ki;
        logic [GAIN_W-1:0]  inner_kd;
        logic [RECIP_W-1:0] recip;
        logic [PWM_W-1:0]   pwm_fs;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic no_shift;
    } mul_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;

endpackage

// ===== design/cascaded_pi_duty_controller.sv =====
`timescale 1ns / 1ps
// Each input transfer is one control tick and yields exactly one result transfer. An enabled
// tick runs the soft-start ramp, then the voltage PID, the current PID and the duty scaling,
// which share one bit-serial multiplier for nine multiplications; each one holds the sequencer
// in a wait state until the multiplier reports done. A disabled tick skips the multiplier and
// registers its soft-shutdown result directly. The multiplier is the pacing unit; one tick is
// processed at a time and the next input is taken once the result has been transferred.
// The user must write configuration over the APB port only while idle; the block itself does
// not enforce this.
module cascaded_pi_duty_controller #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpdc_pkg::ADDR_W-1:0]  paddr,
    input  logic [cpdc_pkg::DATA_W-1:0]  pwdata,
    output logic [cpdc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_loop_enable,
    input  logic [21:0]                  s_rms_setpoint,
    input  logic signed [31:0]           s_measured_rms,
    input  logic [16:0]                  s_sine_magnitude,
    input  logic signed [31:0]           s_measured_current,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [11:0]                  m_duty_compare,
    output logic                         m_both_channels
);

    localparam int W = VALUE_WIDTH;
    localparam int F = FRACTION_BITS;

    localparam logic [W-1:0] VMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;

    localparam logic signed [63:0] RAW_STEP = ((64'sd1000 <<< F) + 64'sd500000) / 64'sd1000000;
    localparam logic signed [63:0] RAW_DOWN = ((64'sd660000 <<< F) + 64'sd500000) / 64'sd1000000;
    localparam logic signed [63:0] RAW_VLIM =
        ((64'sd2828000 <<< F) + 64'sd500000) / 64'sd1000000;
    localparam logic signed [63:0] RAW_LIM =
        ((64'sd50000000 <<< F) + 64'sd500000) / 64'sd1000000;
    localparam logic signed [63:0] RAW_ONE = 64'sd1 <<< F;

    localparam logic [W-1:0] C_STEP = (RAW_STEP > VMAX64) ? VMAX_W : RAW_STEP[W-1:0];
    localparam logic [W-1:0] C_DOWN = (RAW_DOWN > VMAX64) ? VMAX_W : RAW_DOWN[W-1:0];
    localparam logic [W-1:0] C_VLIM = (RAW_VLIM > VMAX64) ? VMAX_W : RAW_VLIM[W-1:0];
    localparam logic [W-1:0] C_LIM  = (RAW_LIM  > VMAX64) ? VMAX_W : RAW_LIM[W-1:0];
    localparam logic [W-1:0] C_ONE  = (RAW_ONE  > VMAX64) ? VMAX_W : RAW_ONE[W-1:0];

    localparam logic [63:0] CMP_MAX = 64'd2200;
    localparam logic [63:0] CMP_MIN = 64'd50;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DIS    = 5'd1;
    localparam logic [4:0] S_RAMP   = 5'd2;
    localparam logic [4:0] S_ERR    = 5'd3;
    localparam logic [4:0] S_DIFF   = 5'd4;
    localparam logic [4:0] S_MKD    = 5'd5;
    localparam logic [4:0] S_MKP    = 5'd6;
    localparam logic [4:0] S_MKI    = 5'd7;
    localparam logic [4:0] S_INT    = 5'd8;
    localparam logic [4:0] S_SUM1   = 5'd9;
    localparam logic [4:0] S_SUM2   = 5'd10;
    localparam logic [4:0] S_VLIM   = 5'd11;
    localparam logic [4:0] S_MREF   = 5'd12;
    localparam logic [4:0] S_SETREF = 5'd13;
    localparam logic [4:0] S_DSUM   = 5'd14;
    localparam logic [4:0] S_MPWM   = 5'd15;
    localparam logic [4:0] S_FIN    = 5'd16;
    localparam logic [4:0] S_WAIT   = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    function automatic logic [W-1:0] sat_ext(input logic signed [63:0] x);
        if (x > VMAX64) begin
            return VMAX_W;
        end else if (x < VMIN64) begin
            return VMIN_W;
        end
        return x[W-1:0];
    endfunction

    function automatic logic [W-1:0] add_sat(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic sub);
        logic signed [W:0] s;
        s = sub ? ($signed({a[W-1], a}) - $signed({b[W-1], b}))
                : ($signed({a[W-1], a}) + $signed({b[W-1], b}));
        if (s[W] != s[W-1]) begin
            return s[W] ? VMIN_W : VMAX_W;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] clamp_sym(input logic [W-1:0] x, input logic [W-1:0] lim);
        logic [W-1:0] nlim;
        nlim = ~lim + 1'b1;
        if ($signed(x) > $signed(lim)) begin
            return lim;
        end else if ($signed(x) < $signed(nlim)) begin
            return nlim;
        end
        return x;
    endfunction

    cpdc_pkg::cfg_t     cfg;
    cpdc_pkg::mul_cmd_t mul_cmd;
    cpdc_pkg::mul_sts_t mul_sts;
    logic [W-1:0]       mul_a, mul_b, mul_res;

    logic [4:0]   state_reg, ret_reg;
    logic         pid_sel_reg;
    logic [W-1:0] rr_reg, sc_reg, oerr_reg, oint_reg, ierr_reg, iint_reg;
    logic [W-1:0] sp_reg, rms_reg, mag_reg, cur_reg, ref_reg, fb_reg;
    logic [W-1:0] te_reg, td_reg, tdout_reg, tpout_reg, ts_reg, tout_reg, tv_reg;
    logic         m_valid_reg, both_reg;
    logic [11:0]  duty_reg;

    logic [W-1:0] in_sp, in_rms, in_mag, in_cur, in_cur_abs;
    logic [W-1:0] kp_w, ki_w, kd_w, mag_w, recip_w, pwm_w;
    logic [W-1:0] last_err, cur_int;
    logic [W-1:0] ramp_rr, ramp_sum, err_e, diff_d, int_new, sum1, sum2, vlim_v, dsum_x;
    logic [W-1:0] dis_sub, dis_sc, fin_sc;
    logic [63:0]  dis_sh, fin_sh, fin_cmp64;
    logic [11:0]  dis_cmp, fin_cmp;

    cpdc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpdc_mul #(.W(W), .F(F)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .sts     (mul_sts),
        .result  (mul_res)
    );

    always_comb begin
        in_sp      = sat_ext({42'd0, s_rms_setpoint});
        in_rms     = sat_ext({{32{s_measured_rms[31]}}, s_measured_rms});
        in_mag     = sat_ext({47'd0, s_sine_magnitude});
        in_cur     = sat_ext({{32{s_measured_current[31]}}, s_measured_current});
        in_cur_abs = in_cur[W-1] ? ((in_cur == VMIN_W) ? VMAX_W : (~in_cur + 1'b1)) : in_cur;

        kp_w    = sat_ext({33'd0, pid_sel_reg ? cfg.inner_kp : cfg.outer_kp});
        ki_w    = sat_ext({33'd0, pid_sel_reg ? cfg.inner_ki : cfg.outer_ki});
        kd_w    = sat_ext({33'd0, pid_sel_reg ? cfg.inner_kd : cfg.outer_kd});
        mag_w   = mag_reg;
        recip_w = sat_ext({47'd0, cfg.recip});
        pwm_w   = sat_ext({48'd0, cfg.pwm_fs});

        last_err = pid_sel_reg ? ierr_reg : oerr_reg;
        cur_int  = pid_sel_reg ? iint_reg : oint_reg;

        ramp_sum = add_sat(rr_reg, C_STEP, 1'b0);
        ramp_rr  = ($signed(ramp_sum) >= $signed(sp_reg)) ? sp_reg : ramp_sum;
        err_e    = add_sat(ref_reg, fb_reg, 1'b1);
        diff_d   = add_sat(te_reg, last_err, 1'b1);
        int_new  = clamp_sym(add_sat(cur_int, mul_res, 1'b0), C_LIM);
        sum1     = add_sat(tpout_reg, tdout_reg, 1'b0);
        sum2     = clamp_sym(add_sat(ts_reg, cur_int, 1'b0), C_LIM);
        vlim_v   = add_sat(clamp_sym(tout_reg, C_VLIM), C_VLIM, 1'b0);
        dsum_x   = add_sat(tout_reg, rr_reg, 1'b0);

        // Soft shutdown: the held compare falls by a fixed step and stops at zero.
        dis_sub = add_sat(sc_reg, C_DOWN, 1'b1);
        dis_sc  = dis_sub[W-1] ? '0 : dis_sub;
        dis_sh  = {{(64-W){1'b0}}, dis_sc} >> F;
        dis_cmp = dis_sh[11:0];

        // A negative duty product always maps to the minimum compare.
        fin_sh = {{(64-W){1'b0}}, mul_res} >> F;
        if (mul_res[W-1]) begin
            fin_cmp64 = CMP_MIN;
        end else if (fin_sh >= CMP_MAX) begin
            fin_cmp64 = CMP_MAX;
        end else if (fin_sh <= CMP_MIN) begin
            fin_cmp64 = CMP_MIN;
        end else begin
            fin_cmp64 = fin_sh;
        end
        fin_cmp = fin_cmp64[11:0];
        fin_sc  = sat_ext(fin_cmp64 << F);
    end

    always_comb begin
        mul_cmd.start    = 1'b0;
        mul_cmd.no_shift = 1'b0;
        mul_a            = te_reg;
        mul_b            = kp_w;
        unique case (state_reg)
            S_MKD: begin
                mul_cmd.start = 1'b1;
                mul_a         = td_reg;
                mul_b         = kd_w;
            end
            S_MKP: begin
                mul_cmd.start = 1'b1;
            end
            S_MKI: begin
                mul_cmd.start = 1'b1;
                mul_b         = ki_w;
            end
            S_MREF: begin
                mul_cmd.start = 1'b1;
                mul_a         = tv_reg;
                mul_b         = mag_w;
            end
            S_DSUM: begin
                mul_cmd.start = 1'b1;
                mul_a         = dsum_x;
                mul_b         = recip_w;
            end
            S_MPWM: begin
                mul_cmd.start    = 1'b1;
                mul_cmd.no_shift = 1'b1;
                mul_a            = mul_res;
                mul_b            = pwm_w;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            pid_sel_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            rr_reg      <= C_ONE;
            sc_reg      <= '0;
            oerr_reg    <= '0;
            oint_reg    <= '0;
            ierr_reg    <= '0;
            iint_reg    <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        sp_reg      <= in_sp;
                        rms_reg     <= in_rms;
                        mag_reg     <= in_mag;
                        cur_reg     <= in_cur_abs;
                        pid_sel_reg <= 1'b0;
                        state_reg   <= s_loop_enable ? S_RAMP : S_DIS;
                    end
                end
                S_DIS: begin
                    rr_reg      <= '0;
                    sc_reg      <= dis_sc;
                    duty_reg    <= dis_cmp;
                    both_reg    <= 1'b0;
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_RAMP: begin
                    rr_reg    <= ramp_rr;
                    ref_reg   <= ramp_rr;
                    fb_reg    <= rms_reg;
                    state_reg <= S_ERR;
                end
                S_ERR: begin
                    te_reg    <= err_e;
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    td_reg <= diff_d;
                    if (pid_sel_reg) begin
                        ierr_reg <= te_reg;
                    end else begin
                        oerr_reg <= te_reg;
                    end
                    state_reg <= S_MKD;
                end
                S_MKD: begin
                    ret_reg   <= S_MKP;
                    state_reg <= S_WAIT;
                end
                S_MKP: begin
                    tdout_reg <= mul_res;
                    ret_reg   <= S_MKI;
                    state_reg <= S_WAIT;
                end
                S_MKI: begin
                    tpout_reg <= mul_res;
                    ret_reg   <= S_INT;
                    state_reg <= S_WAIT;
                end
                S_INT: begin
                    if (pid_sel_reg) begin
                        iint_reg <= int_new;
                    end else begin
                        oint_reg <= int_new;
                    end
                    state_reg <= S_SUM1;
                end
                S_SUM1: begin
                    ts_reg    <= sum1;
                    state_reg <= S_SUM2;
                end
                S_SUM2: begin
                    tout_reg  <= sum2;
                    state_reg <= pid_sel_reg ? S_DSUM : S_VLIM;
                end
                S_VLIM: begin
                    tv_reg    <= vlim_v;
                    state_reg <= S_MREF;
                end
                S_MREF: begin
                    ret_reg   <= S_SETREF;
                    state_reg <= S_WAIT;
                end
                S_SETREF: begin
                    ref_reg     <= mul_res;
                    fb_reg      <= cur_reg;
                    pid_sel_reg <= 1'b1;
                    state_reg   <= S_ERR;
                end
                S_DSUM: begin
                    ret_reg   <= S_MPWM;
                    state_reg <= S_WAIT;
                end
                S_MPWM: begin
                    ret_reg   <= S_FIN;
                    state_reg <= S_WAIT;
                end
                S_FIN: begin
                    sc_reg      <= fin_sc;
                    duty_reg    <= fin_cmp;
                    both_reg    <= 1'b1;
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_WAIT: begin
                    if (mul_sts.done) begin
                        state_reg <= ret_reg;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_duty_compare  = duty_reg;
    assign m_both_channels = both_reg;

endmodule

// ===== design/cpdc_regs.sv =====
`timescale 1ns / 1ps
// APB configuration register bank of the duty controller.
module cpdc_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpdc_pkg::ADDR_W-1:0]   paddr,
    input  logic [cpdc_pkg::DATA_W-1:0]   pwdata,
    output logic [cpdc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output cpdc_pkg::cfg_t                cfg
);

    cpdc_pkg::cfg_t cfg_reg;
    logic [cpdc_pkg::IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[cpdc_pkg::ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.outer_kp <= cpdc_pkg::RST_OUTER_KP;
            cfg_reg.outer_ki <= cpdc_pkg::RST_OUTER_KI;
            cfg_reg.outer_kd <= cpdc_pkg::RST_OUTER_KD;
            cfg_reg.inner_kp <= cpdc_pkg::RST_INNER_KP;
            cfg_reg.inner_ki <= cpdc_pkg::RST_INNER_KI;
            cfg_reg.inner_kd <= cpdc_pkg::RST_INNER_KD;
            cfg_reg.recip    <= cpdc_pkg::RST_RECIP;
            cfg_reg.pwm_fs   <= cpdc_pkg::RST_PWM_FS;
        end else if (wr_en) begin
            unique case (idx)
                cpdc_pkg::REG_OUTER_KP: cfg_reg.outer_kp <= pwdata[cpdc_pkg::GAIN_W-1:0];
                cpdc_pkg::REG_OUTER_KI: cfg_reg.outer_ki <= pwdata[cpdc_pkg::GAIN_W-1:0];
                cpdc_pkg::REG_OUTER_KD: cfg_reg.outer_kd <= pwdata[cpdc_pkg::GAIN_W-1:0];
                cpdc_pkg::REG_INNER_KP: cfg_reg.inner_kp <= pwdata[cpdc_pkg::GAIN_W-1:0];
                cpdc_pkg::REG_INNER_KI: cfg_reg.inner_ki <= pwdata[cpdc_pkg::GAIN_W-1:0];
                cpdc_pkg::REG_INNER_KD: cfg_reg.inner_kd <= pwdata[cpdc_pkg::GAIN_W-1:0];
                cpdc_pkg::REG_RECIP:    cfg_reg.recip    <= pwdata[cpdc_pkg::RECIP_W-1:0];
                cpdc_pkg::REG_PWM_FS:   cfg_reg.pwm_fs   <= pwdata[cpdc_pkg::PWM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            cpdc_pkg::REG_OUTER_KP: prdata = {1'b0, cfg_reg.outer_kp};
            cpdc_pkg::REG_OUTER_KI: prdata = {1'b0, cfg_reg.outer_ki};
            cpdc_pkg::REG_OUTER_KD: prdata = {1'b0, cfg_reg.outer_kd};
            cpdc_pkg::REG_INNER_KP: prdata = {1'b0, cfg_reg.inner_kp};
            cpdc_pkg::REG_INNER_KI: prdata = {1'b0, cfg_reg.inner_ki};
            cpdc_pkg::REG_INNER_KD: prdata = {1'b0, cfg_reg.inner_kd};
            cpdc_pkg::REG_RECIP:    prdata = {15'd0, cfg_reg.recip};
            cpdc_pkg::REG_PWM_FS:   prdata = {16'd0, cfg_reg.pwm_fs};
            default:                prdata = '0;
        endcase
    end

endmodule

// ===== design/cpdc_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial saturating fixed-point multiplier, one multiplier bit per cycle.
module cpdc_mul #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cpdc_pkg::mul_cmd_t   cmd,
    input  logic [W-1:0]         op_a,
    input  logic [W-1:0]         op_b,
    output cpdc_pkg::mul_sts_t   sts,
    output logic [W-1:0]         result
);

    localparam int CW = $clog2(W);
    localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

    logic [2*W:0]  acc_reg;
    logic [W-1:0]  ua_reg;
    logic          neg_reg;
    logic          noshift_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          fin_reg;
    logic          done_reg;
    logic [W-1:0]  result_reg;

    logic [W-1:0]   abs_a, abs_b, addend, q, lim, qs;
    logic [W:0]     sum;
    logic [2*W:0]   acc_next;
    logic [2*W-1:0] prod, shifted;

    always_comb begin
        abs_a    = op_a[W-1] ? (~op_a + 1'b1) : op_a;
        abs_b    = op_b[W-1] ? (~op_b + 1'b1) : op_b;
        addend   = acc_reg[0] ? ua_reg : '0;
        sum      = acc_reg[2*W:W] + {1'b0, addend};
        acc_next = {1'b0, sum, acc_reg[W-1:1]};
        prod     = acc_reg[2*W-1:0];
        shifted  = noshift_reg ? prod : (prod >> F);
        q        = shifted[W-1:0];
        lim      = neg_reg ? NEG_LIM : POS_LIM;
        // The magnitude saturates before the sign is applied.
        qs       = ((|shifted[2*W-1:W]) || (q > lim)) ? lim : q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
            end else if (busy_reg) begin
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg     <= {{(W+1){1'b0}}, abs_b};
            ua_reg      <= abs_a;
            neg_reg     <= op_a[W-1] ^ op_b[W-1];
            noshift_reg <= cmd.no_shift;
            cnt_reg     <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_reg + 1'b1;
        end else if (fin_reg) begin
            result_reg <= neg_reg ? (~qs + 1'b1) : qs;
        end
    end

    assign sts.busy = busy_reg | fin_reg;
    assign sts.done = done_reg;
    assign result   = result_reg;

endmodule
